// File: sv/pcab_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcab_pkg
// Shared types and constants for the polygon containment and area block.
// ----------------------------------------------------------------------------
package pcab_pkg;

    localparam int DEF_MAX_VERTICES = 64;
    localparam int DEF_COORD_WIDTH  = 16;
    localparam int SUM_EXTRA_BITS   = 10;

    typedef enum logic {
        OP_ADD  = 1'b0,
        OP_TEST = 1'b1
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EDGE_MUL,
        S_EDGE_ACC,
        S_WALK,
        S_DRAIN,
        S_CLOSE_PREP,
        S_CLOSE_MUL,
        S_CLOSE_SUM,
        S_CLOSE_ABS,
        S_DONE
    } t_state;

    typedef struct packed {
        logic start;
        logic rd_valid;
    } t_cross_ctl;

    typedef struct packed {
        logic busy;
        logic in_poly;
    } t_cross_sts;

endpackage

// File: sv/pcab_vertex_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcab_vertex_ram
// Vertex store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pcab_vertex_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/pcab_cross_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcab_cross_unit
// Even-odd crossing pipeline, one polygon edge per cycle: differences,
// cross-multiplied products, compare and parity toggle.
// ----------------------------------------------------------------------------
module pcab_cross_unit #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pcab_pkg::t_cross_ctl          i_ctl,
    input  logic signed [COORD_WIDTH-1:0] i_px,
    input  logic signed [COORD_WIDTH-1:0] i_py,
    input  logic signed [COORD_WIDTH-1:0] i_start_x,
    input  logic signed [COORD_WIDTH-1:0] i_start_y,
    input  logic signed [COORD_WIDTH-1:0] i_rd_x,
    input  logic signed [COORD_WIDTH-1:0] i_rd_y,
    output pcab_pkg::t_cross_sts          o_sts
);

    import pcab_pkg::*;

    localparam int D_W = COORD_WIDTH + 1;
    localparam int P_W = 2 * D_W;

    logic signed [COORD_WIDTH-1:0] r_prev_x;
    logic signed [COORD_WIDTH-1:0] r_prev_y;

    logic                  r_a_vld;
    logic                  r_a_str;
    logic signed [D_W-1:0] r_dy;
    logic signed [D_W-1:0] r_dxp;
    logic signed [D_W-1:0] r_dxe;
    logic signed [D_W-1:0] r_dyp;

    logic                  r_b_vld;
    logic                  r_b_str;
    logic                  r_b_neg;
    logic signed [P_W-1:0] r_lhs;
    logic signed [P_W-1:0] r_rhs;

    logic r_inside;
    logic above_i;
    logic above_j;
    logic x_hit;

    assign above_i = i_py < i_rd_y;
    assign above_j = i_py < r_prev_y;
    assign x_hit   = r_b_neg ? (r_rhs < r_lhs) : (r_lhs < r_rhs);

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_prev_x <= i_start_x;
            r_prev_y <= i_start_y;
        end else if (i_ctl.rd_valid) begin
            r_prev_x <= i_rd_x;
            r_prev_y <= i_rd_y;
        end
        r_a_str <= above_i != above_j;
        r_dy    <= D_W'(r_prev_y) - D_W'(i_rd_y);
        r_dxp   <= D_W'(i_px) - D_W'(i_rd_x);
        r_dxe   <= D_W'(r_prev_x) - D_W'(i_rd_x);
        r_dyp   <= D_W'(i_py) - D_W'(i_rd_y);
        r_b_str <= r_a_str;
        r_b_neg <= r_dy[D_W-1];
        r_lhs   <= r_dxp * r_dy;
        r_rhs   <= r_dxe * r_dyp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld  <= 1'b0;
            r_b_vld  <= 1'b0;
            r_inside <= 1'b0;
        end else begin
            r_a_vld <= i_ctl.rd_valid;
            r_b_vld <= r_a_vld;
            if (i_ctl.start) begin
                r_inside <= 1'b0;
            end else if (r_b_vld && r_b_str && x_hit) begin
                r_inside <= ~r_inside;
            end
        end
    end

    assign o_sts.busy    = r_a_vld | r_b_vld;
    assign o_sts.in_poly = r_inside;

endmodule

// File: sv/polygon_containment_area_bounds.sv
// sequence: an add runs the edge multiply and accumulate steps, then the closing prep, multiply,
// sum and abs steps (a first or refused add skips the edge steps); a test walks the n stored vertices,
// drains the crossing pipeline and runs the same closing steps (straight to them when empty); requests
// are taken one at a time, only in idle, and a test walks the single read port one edge a cycle
// reset: empty polygon, zero area and bounds; store contents need no clearing
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polygon_containment_area_bounds
// Vertex table with running shoelace sum and bounding box; even-odd point
// test by walking the stored edges through the crossing pipeline.
// ----------------------------------------------------------------------------
module polygon_containment_area_bounds #(
    parameter int MAX_VERTICES = pcab_pkg::DEF_MAX_VERTICES,
    parameter int COORD_WIDTH  = pcab_pkg::DEF_COORD_WIDTH
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic                                   i_operation,
    input  logic signed [COORD_WIDTH-1:0]          i_x,
    input  logic signed [COORD_WIDTH-1:0]          i_y,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic                                   o_inside_res,
    output logic                                   o_table_full,
    output logic [$clog2(MAX_VERTICES+1)-1:0]      o_vertex_count,
    output logic [2*COORD_WIDTH+pcab_pkg::SUM_EXTRA_BITS-2:0] o_twice_area,
    output logic signed [COORD_WIDTH-1:0]          o_min_x,
    output logic signed [COORD_WIDTH-1:0]          o_max_x,
    output logic signed [COORD_WIDTH-1:0]          o_min_y,
    output logic signed [COORD_WIDTH-1:0]          o_max_y
);

    import pcab_pkg::*;

    localparam int AW     = $clog2(MAX_VERTICES);
    localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
    localparam int D_W    = COORD_WIDTH + 1;
    localparam int P_W    = 2 * D_W;
    localparam int SUM_W  = 2 * COORD_WIDTH + SUM_EXTRA_BITS;
    localparam int AREA_W = SUM_W - 1;

    t_state r_state;
    t_state n_state;

    logic accept;
    logic add_ok;
    logic out_free;
    logic walk_last;

    logic                          r_op;
    logic signed [COORD_WIDTH-1:0] r_px;
    logic signed [COORD_WIDTH-1:0] r_py;
    logic                          r_full;
    logic [CNT_W-1:0]              r_count;
    logic [AW-1:0]                 r_addr;
    logic                          r_rd_pend;

    logic signed [COORD_WIDTH-1:0] r_first_x;
    logic signed [COORD_WIDTH-1:0] r_first_y;
    logic signed [COORD_WIDTH-1:0] r_last_x;
    logic signed [COORD_WIDTH-1:0] r_last_y;
    logic signed [COORD_WIDTH-1:0] r_min_x;
    logic signed [COORD_WIDTH-1:0] r_max_x;
    logic signed [COORD_WIDTH-1:0] r_min_y;
    logic signed [COORD_WIDTH-1:0] r_max_y;

    logic signed [D_W-1:0]         r_ma;
    logic signed [D_W-1:0]         r_mb;
    logic signed [P_W-1:0]         r_prod;
    logic [SUM_W-1:0]              r_edge_sum;
    logic [SUM_W-1:0]              r_total;
    logic [AREA_W-1:0]             r_area;

    logic                          r_o_valid;
    logic                          r_o_inside;
    logic                          r_o_full;
    logic [CNT_W-1:0]              r_o_count;
    logic [AREA_W-1:0]             r_o_area;
    logic signed [COORD_WIDTH-1:0] r_o_min_x;
    logic signed [COORD_WIDTH-1:0] r_o_max_x;
    logic signed [COORD_WIDTH-1:0] r_o_min_y;
    logic signed [COORD_WIDTH-1:0] r_o_max_y;

    logic [2*COORD_WIDTH-1:0]      rd_data;
    logic [SUM_W-1:0]              total_neg;
    t_cross_ctl                    cross_ctl;
    t_cross_sts                    cross_sts;

    assign accept    = (r_state == S_IDLE) && i_in_valid;
    assign add_ok    = r_count != CNT_W'(MAX_VERTICES);
    assign out_free  = !r_o_valid || i_out_ready;
    assign walk_last = (CNT_W'(r_addr) + CNT_W'(1)) == r_count;
    assign total_neg = -r_total;

    assign cross_ctl.start    = accept && (t_op'(i_operation) == OP_TEST);
    assign cross_ctl.rd_valid = r_rd_pend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (t_op'(i_operation) == OP_TEST) begin
                        n_state = (r_count == '0) ? S_CLOSE_PREP : S_WALK;
                    end else if (add_ok && r_count != '0) begin
                        n_state = S_EDGE_MUL;
                    end else begin
                        n_state = S_CLOSE_PREP;
                    end
                end
            end
            S_EDGE_MUL:   n_state = S_EDGE_ACC;
            S_EDGE_ACC:   n_state = S_CLOSE_PREP;
            S_WALK: begin
                if (walk_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!r_rd_pend && !cross_sts.busy) begin
                    n_state = S_CLOSE_PREP;
                end
            end
            S_CLOSE_PREP: n_state = S_CLOSE_MUL;
            S_CLOSE_MUL:  n_state = S_CLOSE_SUM;
            S_CLOSE_SUM:  n_state = S_CLOSE_ABS;
            S_CLOSE_ABS:  n_state = S_DONE;
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:      n_state = S_IDLE;
        endcase
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op <= i_operation;
            r_px <= i_x;
            r_py <= i_y;
            r_ma <= D_W'(r_last_x) + D_W'(i_x);
            r_mb <= D_W'(r_last_y) - D_W'(i_y);
            if (t_op'(i_operation) == OP_ADD && add_ok) begin
                r_last_x <= i_x;
                r_last_y <= i_y;
                if (r_count == '0) begin
                    r_first_x <= i_x;
                    r_first_y <= i_y;
                end
            end
        end
        if (r_state == S_CLOSE_PREP) begin
            r_ma <= D_W'(r_last_x) + D_W'(r_first_x);
            r_mb <= D_W'(r_last_y) - D_W'(r_first_y);
        end
        if (r_state == S_EDGE_MUL || r_state == S_CLOSE_MUL) begin
            r_prod <= r_ma * r_mb;
        end
        if (r_state == S_CLOSE_SUM) begin
            r_total <= r_edge_sum + SUM_W'(r_prod);
        end
        if (r_state == S_CLOSE_ABS) begin
            if (r_count == '0) begin
                r_area <= '0;
            end else if (r_total[SUM_W-1]) begin
                r_area <= total_neg[AREA_W-1:0];
            end else begin
                r_area <= r_total[AREA_W-1:0];
            end
        end
        if (r_state == S_DONE && out_free) begin
            r_o_inside <= (t_op'(r_op) == OP_TEST) ? cross_sts.in_poly : 1'b0;
            r_o_full   <= r_full;
            r_o_count  <= r_count;
            r_o_area   <= r_area;
            r_o_min_x  <= r_min_x;
            r_o_max_x  <= r_max_x;
            r_o_min_y  <= r_min_y;
            r_o_max_y  <= r_max_y;
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_edge_sum <= '0;
            r_full     <= 1'b0;
            r_addr     <= '0;
            r_rd_pend  <= 1'b0;
            r_o_valid  <= 1'b0;
            r_min_x    <= '0;
            r_max_x    <= '0;
            r_min_y    <= '0;
            r_max_y    <= '0;
        end else begin
            r_rd_pend <= (r_state == S_WALK);
            if (accept) begin
                r_addr <= '0;
                r_full <= (t_op'(i_operation) == OP_ADD) && !add_ok;
                if (t_op'(i_operation) == OP_ADD && add_ok) begin
                    r_count <= r_count + CNT_W'(1);
                    if (r_count == '0) begin
                        r_min_x <= i_x;
                        r_max_x <= i_x;
                        r_min_y <= i_y;
                        r_max_y <= i_y;
                    end else begin
                        if (i_x < r_min_x) r_min_x <= i_x;
                        if (i_x > r_max_x) r_max_x <= i_x;
                        if (i_y < r_min_y) r_min_y <= i_y;
                        if (i_y > r_max_y) r_max_y <= i_y;
                    end
                end
            end
            if (r_state == S_WALK) begin
                r_addr <= r_addr + AW'(1);
            end
            if (r_state == S_EDGE_ACC) begin
                r_edge_sum <= r_edge_sum + SUM_W'(r_prod);
            end
            if (r_state == S_DONE && out_free) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    pcab_vertex_ram #(
        .DEPTH (MAX_VERTICES),
        .WIDTH (2 * COORD_WIDTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (accept && t_op'(i_operation) == OP_ADD && add_ok),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata ({i_x, i_y}),
        .i_re    (r_state == S_WALK),
        .i_raddr (r_addr),
        .o_rdata (rd_data)
    );

    pcab_cross_unit #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_cross (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (cross_ctl),
        .i_px      (r_px),
        .i_py      (r_py),
        .i_start_x (r_last_x),
        .i_start_y (r_last_y),
        .i_rd_x    (rd_data[2*COORD_WIDTH-1:COORD_WIDTH]),
        .i_rd_y    (rd_data[COORD_WIDTH-1:0]),
        .o_sts     (cross_sts)
    );

    assign o_in_ready     = (r_state == S_IDLE);
    assign o_out_valid    = r_o_valid;
    assign o_inside_res   = r_o_inside;
    assign o_table_full   = r_o_full;
    assign o_vertex_count = r_o_count;
    assign o_twice_area   = r_o_area;
    assign o_min_x        = r_o_min_x;
    assign o_max_x        = r_o_max_x;
    assign o_min_y        = r_o_min_y;
    assign o_max_y        = r_o_max_y;

endmodule
